// ===== src/thi_pkg.sv =====
// Package with the shared types and constants of the table hunt interpolator.
package thi_pkg;

    localparam int unsigned TableDepth = 256;
    localparam int unsigned IdxW       = 8;
    localparam int unsigned CntW       = 9;
    localparam int unsigned ValW       = 32;

    typedef enum logic [0:0] {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_LOW    = 2'd1;
    localparam logic [1:0] ST_HIGH   = 2'd2;
    localparam logic [1:0] ST_ZERO   = 2'd3;

    // One queued item between the front and the back.
    typedef struct packed {
        t_cmd                   cmd;
        logic [IdxW-1:0]        idx;
        logic signed [ValW-1:0] x;
        logic signed [ValW-1:0] y;
    } t_item;

    // One finished lookup result.
    typedef struct packed {
        logic signed [ValW-1:0] y;
        logic [1:0]             status;
    } t_result;

endpackage

// ===== src/table_hunt_interpolator.sv =====
// Top level of the table hunt interpolator. A clamped lookup ends after the end-point reads.
// An interpolated lookup runs the bisection probes, with a valid hint the hint and hunt probes
// before them, and then the serial divider, which dominates. Throughput: one write per cycle
// while the back part is idle; one lookup in the back part at a time, a two-entry queue in
// front and a result register behind, so a waiting result holds only the next result.
// Synchronous active-low reset clears control, the count (to 2) and the search hint.
module table_hunt_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_cmd,
    input  logic [7:0]         i_point_index,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_y_result,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_data
);
    import thi_pkg::*;

    logic    wr, qfull, qvalid, take, rv;
    t_item   item_in, item_out;
    t_result res;
    logic [8:0] cnt;

    thi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(i_cmd),
        .i_point_index(i_point_index), .i_x_value(i_x_value), .i_y_value(i_y_value),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .o_full(full), .o_wr(wr),
        .o_item(item_in), .i_q_full(qfull), .o_point_count(cnt)
    );

    thi_item_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(wr), .i_data(item_in), .o_full(qfull),
        .i_rd(take), .o_valid(qvalid), .o_data(item_out)
    );

    thi_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_point_count(cnt), .i_cfg_we(i_cfg_we),
        .i_valid(qvalid), .i_item(item_out), .o_take(take), .o_res_valid(rv),
        .o_res(res), .i_res_take(pop)
    );

    // Result register drives the output side.
    assign empty      = !rv;
    assign o_y_result = res.y;
    assign o_status   = res.status;
endmodule

// ===== src/thi_item_fifo.sv =====
// Short item queue between the front and the back.
module thi_item_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  thi_pkg::t_item i_data,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output thi_pkg::t_item o_data
);
    import thi_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // Storage is written without reset.
    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_rd && o_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, (i_wr && !o_full)} - {1'b0, (i_rd && o_valid)};
        end
    end
endmodule

// ===== src/thi_engine.sv =====
// Back part: table memories, hunt and bisection sequencer, serial divider.
module thi_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [8:0]       i_point_count,
    input  logic             i_cfg_we,
    input  logic             i_valid,
    input  thi_pkg::t_item   i_item,
    output logic             o_take,
    output logic             o_res_valid,
    output thi_pkg::t_result o_res,
    input  logic             i_res_take
);
    import thi_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_ENDS  = 12'b000000000010,
        S_ENDW  = 12'b000000000100,
        S_CLAMP = 12'b000000001000,
        S_PROBE = 12'b000000010000,
        S_PWAIT = 12'b000000100000,
        S_PDEC  = 12'b000001000000,
        S_SEG   = 12'b000010000000,
        S_SEGW  = 12'b000100000000,
        S_MUL   = 12'b001000000000,
        S_DIV   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    // Probe phases of the bracket search.
    typedef enum logic [2:0] {
        P_HINT = 3'b001,
        P_HUNT = 3'b010,
        P_BIS  = 3'b100
    } t_phase;

    logic signed [ValW-1:0] r_xm [TableDepth];
    logic signed [ValW-1:0] r_ym [TableDepth];

    t_state r_st;
    t_phase r_ph;
    logic [IdxW-1:0] r_ra, r_rb;
    logic signed [ValW-1:0] r_xa, r_ya, r_xb, r_yb;
    logic signed [ValW-1:0] r_x, r_x0, r_y0;
    logic [CntW-1:0] r_n, r_lo, r_hi, r_inc, r_hint;
    logic r_hint_ok, r_asc, r_up;
    logic [63:0] r_prod, r_rem, r_q;
    logic [32:0] r_dx;
    logic [6:0] r_cnt;
    logic r_neg;
    logic signed [ValW-1:0] r_yl;
    t_result r_pend;
    t_result r_res;
    logic r_rv;

    logic [CntW-1:0] n_cnt_sat;
    logic pass_a;
    logic [CntW-1:0] mid;
    logic [32:0] dy, dt;
    logic ny, nt, nx;
    logic [64:0] rsh;
    logic [63:0] qr;
    logic [ValW-1:0] sum;

    assign n_cnt_sat = (i_point_count < 9'd2)   ? 9'd2 :
                       (i_point_count > 9'd256) ? 9'd256 : i_point_count;
    assign pass_a    = ((r_x >= r_xa) == r_asc);
    assign mid       = (r_lo + r_hi) >> 1;
    // The result register parts the search from the output; an item is taken only while the sequencer is idle.
    assign o_take    = (r_st == S_IDLE) && i_valid;
    assign o_res_valid = r_rv;
    assign o_res     = r_res;

    // Table ports: one write, two registered reads.
    always_ff @(posedge i_clk) begin
        if (o_take && i_item.cmd == CMD_WRITE) begin
            r_xm[i_item.idx] <= i_item.x;
            r_ym[i_item.idx] <= i_item.y;
        end
        r_xa <= r_xm[r_ra];
        r_ya <= r_ym[r_ra];
        r_xb <= r_xm[r_rb];
        r_yb <= r_ym[r_rb];
    end

    // Segment differences, signs and the divider step.
    always_comb begin
        ny = (r_yb < r_ya);
        nx = (r_xb < r_xa);
        nt = (r_x < r_xa);
        dy = ny ? ({r_ya[ValW-1], r_ya} - {r_yb[ValW-1], r_yb})
                : ({r_yb[ValW-1], r_yb} - {r_ya[ValW-1], r_ya});
        dt = nt ? ({r_xa[ValW-1], r_xa} - {r_x[ValW-1], r_x})
                : ({r_x[ValW-1], r_x} - {r_xa[ValW-1], r_xa});
        rsh = {r_rem, r_prod[63]};
        qr  = r_q + 64'd1;
        sum = r_neg ? (r_yl - qr[ValW-1:0]) : (r_yl + qr[ValW-1:0]);
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_hint_ok <= 1'b0;
            r_rv      <= 1'b0;
            r_ph      <= P_HINT;
        end else begin
            if (i_res_take && r_rv) begin
                r_rv <= 1'b0;
            end
            if (i_cfg_we) begin
                r_hint_ok <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (o_take) begin
                        if (i_item.cmd == CMD_WRITE) begin
                            r_hint_ok <= 1'b0;
                        end else begin
                            r_x  <= i_item.x;
                            r_n  <= n_cnt_sat;
                            r_ra <= '0;
                            r_rb <= IdxW'(n_cnt_sat - 9'd1);
                            r_st <= S_ENDS;
                        end
                    end
                end
                S_ENDS: r_st <= S_ENDW;
                S_ENDW: begin
                    r_x0  <= r_xa;
                    r_y0  <= r_ya;
                    r_asc <= (r_xb >= r_xa);
                    r_st  <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (r_asc ? (r_x <= r_x0) : (r_x >= r_x0)) begin
                        r_pend    <= '{y: r_y0, status: ST_LOW};
                        r_hint    <= '0;
                        r_hint_ok <= 1'b1;
                        r_st      <= S_DONE;
                    end else if (r_asc ? (r_x >= r_xb) : (r_x <= r_xb)) begin
                        r_pend    <= '{y: r_yb, status: ST_HIGH};
                        r_hint    <= r_n - 9'd2;
                        r_hint_ok <= 1'b1;
                        r_st      <= S_DONE;
                    end else if (!r_hint_ok || r_hint >= r_n - 9'd1) begin
                        r_lo <= '0;
                        r_hi <= r_n - 9'd1;
                        r_ph <= P_BIS;
                        r_st <= S_PROBE;
                    end else begin
                        r_ra <= r_hint[IdxW-1:0];
                        r_ph <= P_HINT;
                        r_st <= S_PWAIT;
                    end
                end
                S_PROBE: begin
                    // Bisection: probe the midpoint or finish.
                    if (r_hi - r_lo > 9'd1) begin
                        r_ra <= mid[IdxW-1:0];
                        r_st <= S_PWAIT;
                    end else begin
                        r_st <= S_SEG;
                    end
                end
                S_PWAIT: r_st <= S_PDEC;
                S_PDEC: begin
                    unique case (r_ph)
                        P_HINT: begin
                            r_inc <= 9'd1;
                            r_up  <= pass_a;
                            r_ph  <= P_HUNT;
                            if (pass_a) begin
                                r_lo <= r_hint;
                                r_hi <= r_hint + 9'd1;
                                r_ra <= IdxW'(r_hint + 9'd1);
                            end else begin
                                r_hi <= r_hint;
                                r_lo <= r_hint - 9'd1;
                                r_ra <= IdxW'(r_hint - 9'd1);
                            end
                            r_st <= S_PWAIT;
                        end
                        P_HUNT: begin
                            if (r_up) begin
                                if (!pass_a) begin
                                    r_ph <= P_BIS;
                                    r_st <= S_PROBE;
                                end else begin
                                    r_lo  <= r_hi;
                                    r_inc <= r_inc << 1;
                                    if ((r_inc << 1) >= r_n - 9'd1 - r_hi) begin
                                        r_hi <= r_n - 9'd1;
                                        r_ph <= P_BIS;
                                        r_st <= S_PROBE;
                                    end else begin
                                        r_hi <= r_hi + (r_inc << 1);
                                        r_ra <= IdxW'(r_hi + (r_inc << 1));
                                        r_st <= S_PWAIT;
                                    end
                                end
                            end else begin
                                if (pass_a) begin
                                    r_ph <= P_BIS;
                                    r_st <= S_PROBE;
                                end else begin
                                    r_hi  <= r_lo;
                                    r_inc <= r_inc << 1;
                                    if ((r_inc << 1) >= r_lo) begin
                                        r_lo <= '0;
                                        r_ph <= P_BIS;
                                        r_st <= S_PROBE;
                                    end else begin
                                        r_lo <= r_lo - (r_inc << 1);
                                        r_ra <= IdxW'(r_lo - (r_inc << 1));
                                        r_st <= S_PWAIT;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (pass_a) begin
                                r_lo <= mid;
                            end else begin
                                r_hi <= mid;
                            end
                            r_st <= S_PROBE;
                        end
                    endcase
                end
                S_SEG: begin
                    r_ra      <= r_lo[IdxW-1:0];
                    r_rb      <= IdxW'(r_lo + 9'd1);
                    r_hint    <= r_lo;
                    r_hint_ok <= 1'b1;
                    r_st      <= S_SEGW;
                end
                S_SEGW: r_st <= S_MUL;
                S_MUL: begin
                    r_yl <= r_ya;
                    r_neg <= ny ^ nt ^ nx;
                    r_dx <= nx ? ({r_xa[ValW-1], r_xa} - {r_xb[ValW-1], r_xb})
                               : ({r_xb[ValW-1], r_xb} - {r_xa[ValW-1], r_xa});
                    if (r_xa == r_xb) begin
                        r_pend <= '{y: r_ya, status: ST_ZERO};
                        r_st   <= S_DONE;
                    end else begin
                        r_pend <= '{y: r_ya, status: ST_INTERP};
                        r_prod <= 64'(dy) * 64'(dt);
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_cnt  <= '0;
                        r_st   <= S_DIV;
                    end
                end
                S_DIV: begin
                    // One restoring quotient bit per cycle.
                    r_prod <= r_prod << 1;
                    if (rsh >= {32'd0, r_dx}) begin
                        r_rem <= 64'(rsh - {32'd0, r_dx});
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= rsh[63:0];
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) begin
                        r_st <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hand the result over once the result register is free.
                    if (!r_rv) begin
                        r_rv <= 1'b1;
                        if (r_pend.status == ST_INTERP) begin
                            if (r_rem >= 64'(r_dx) - r_rem) begin
                                r_res <= '{y: sum, status: ST_INTERP};
                            end else begin
                                r_res <= '{y: (r_neg ? r_yl - r_q[ValW-1:0]
                                                     : r_yl + r_q[ValW-1:0]),
                                           status: ST_INTERP};
                            end
                        end else begin
                            r_res <= r_pend;
                        end
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/thi_front.sv =====
// Front part: input handshake, item classification into the queue and the point count register.
module thi_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_cmd,
    input  logic [7:0]             i_point_index,
    input  logic signed [31:0]     i_x_value,
    input  logic signed [31:0]     i_y_value,
    input  logic                   i_cfg_we,
    input  logic [8:0]             i_cfg_data,
    output logic                   o_full,
    output logic                   o_wr,
    output thi_pkg::t_item         o_item,
    input  logic                   i_q_full,
    output logic [8:0]             o_point_count
);
    import thi_pkg::*;

    logic [8:0] r_count;

    // Classify the command and pack the item.
    assign o_full = i_q_full;
    assign o_wr   = i_push && !i_q_full;
    assign o_item = '{cmd: (i_cmd ? CMD_LOOKUP : CMD_WRITE), idx: i_point_index,
                      x: i_x_value, y: i_y_value};
    assign o_point_count = r_count;

    // Point count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 9'd2;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end
endmodule

// ===== src/thi_checker.sv =====
// Port-level checker for the table hunt interpolator, with its bind.
module thi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               push,
    input logic               empty,
    input logic               pop,
    input logic signed [31:0] o_y_result,
    input logic [1:0]         o_status
);
    // A waiting result holds until it is popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_y_result) && $stable(o_status)))
        else $error("result changed while waiting");

    // After reset nothing waits.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

    // The result side stays empty right after a pop: one lookup at a time.
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop) |=> empty)
        else $error("second result right after pop");

    // After reset the input side is not full.
    a_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");
endmodule

bind table_hunt_interpolator thi_checker u_thi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full), .push(push), .empty(empty),
    .pop(pop), .o_y_result(o_y_result), .o_status(o_status)
);

// ===== tb/tb_top.sv =====
// Testbench for the table hunt interpolator: a breakpoint predictor with a result scoreboard.
`timescale 1ns / 100ps

import thi_pkg::*;

// Predicts lookup results from its own copy of the table and checks the results that come out.
class interp_scoreboard;
    logic signed [31:0] x_tab [256];
    logic signed [31:0] y_tab [256];
    int unsigned        count_in_use;
    int unsigned        hint;
    bit                 hint_valid;
    logic signed [31:0] want_y [$];
    logic [1:0]         want_status [$];
    int                 errors;
    int                 results_seen;
    int                 clamp_seen;
    int                 interp_seen;

    function void clear();
        count_in_use = 2;
        hint_valid = 0;
        hint = 0;
        errors = 0;
        want_y.delete();
        want_status.delete();
    endfunction

    function void set_count(logic [8:0] value);
        count_in_use = value;
        hint_valid = 0;
    endfunction

    function bit at_or_past(logic signed [31:0] x, int unsigned j, bit asc);
        return (x >= x_tab[j]) == asc;
    endfunction

    // Note one accepted input transfer and queue its expected result if it is a lookup.
    function void note_input(t_cmd cmd, logic [7:0] idx, logic signed [31:0] x,
                             logic signed [31:0] y);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned inc;
        int unsigned m;
        bit asc;
        bit neg;
        longint signed dy;
        longint signed dx;
        longint signed dt;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [63:0] q;
        if (cmd == CMD_WRITE) begin
            x_tab[idx] = x;
            y_tab[idx] = y;
            hint_valid = 0;
            return;
        end
        n = count_in_use < 2 ? 2 : (count_in_use > 256 ? 256 : count_in_use);
        asc = x_tab[n-1] >= x_tab[0];
        if (asc ? (x <= x_tab[0]) : (x >= x_tab[0])) begin
            want_y.push_back(y_tab[0]);
            want_status.push_back(ST_LOW);
            hint = 0;
            hint_valid = 1;
            return;
        end
        if (asc ? (x >= x_tab[n-1]) : (x <= x_tab[n-1])) begin
            want_y.push_back(y_tab[n-1]);
            want_status.push_back(ST_HIGH);
            hint = n - 2;
            hint_valid = 1;
            return;
        end
        // Hunt outward from the previous hit, then bisect.
        if (!hint_valid || hint >= n - 1) begin
            lo = 0;
            hi = n - 1;
        end else if (at_or_past(x, hint, asc)) begin
            lo = hint;
            hi = lo + 1;
            inc = 1;
            while (at_or_past(x, hi, asc)) begin
                lo = hi;
                inc = inc << 1;
                if (inc >= n - 1 - lo) begin
                    hi = n - 1;
                    break;
                end
                hi = lo + inc;
            end
        end else begin
            hi = hint;
            lo = hi - 1;
            inc = 1;
            while (!at_or_past(x, lo, asc)) begin
                hi = lo;
                inc = inc << 1;
                if (inc >= hi) begin
                    lo = 0;
                    break;
                end
                lo = hi - inc;
            end
        end
        while (hi - lo > 1) begin
            m = (lo + hi) >> 1;
            if (at_or_past(x, m, asc)) lo = m;
            else hi = m;
        end
        hint = lo;
        hint_valid = 1;
        dy = longint'(y_tab[lo+1]) - longint'(y_tab[lo]);
        dx = longint'(x_tab[lo+1]) - longint'(x_tab[lo]);
        dt = longint'(x) - longint'(x_tab[lo]);
        if (dx == 0) begin
            want_y.push_back(y_tab[lo]);
            want_status.push_back(ST_ZERO);
            return;
        end
        neg = (dy < 0) ^ (dx < 0) ^ (dt < 0);
        if (dy < 0) dy = -dy;
        if (dx < 0) dx = -dx;
        if (dt < 0) dt = -dt;
        prod = 128'(dy) * 128'(dt);
        quo = prod / 128'(dx);
        rem = prod % 128'(dx);
        q = quo[63:0];
        // Round to nearest, ties away from zero.
        if (rem >= 128'(dx) - rem) q = q + 1;
        want_y.push_back(neg ? y_tab[lo] - q[31:0] : y_tab[lo] + q[31:0]);
        want_status.push_back(ST_INTERP);
    endfunction

    // Check one accepted result transfer against the oldest expectation.
    function void check_result(logic signed [31:0] y, logic [1:0] status);
        logic signed [31:0] ey;
        logic [1:0] es;
        results_seen++;
        if (want_y.size() == 0) begin
            $error("result y_result=%0d status=%0d with nothing expected", y, status);
            errors++;
            return;
        end
        ey = want_y.pop_front();
        es = want_status.pop_front();
        if (status == ST_INTERP) interp_seen++;
        else clamp_seen++;
        if (y !== ey) begin
            $error("y_result expected %0d actual %0d", ey, y);
            errors++;
        end
        if (status !== es) begin
            $error("status expected %0d actual %0d", es, status);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               push = 0;
    logic               full;
    logic               i_cmd = 0;
    logic [7:0]         i_point_index = 0;
    logic signed [31:0] i_x_value = 0;
    logic signed [31:0] i_y_value = 0;
    logic               empty;
    logic               pop = 0;
    logic signed [31:0] o_y_result;
    logic [1:0]         o_status;
    logic               i_cfg_we = 0;
    logic [8:0]         i_cfg_data = 0;

    interp_scoreboard board;
    bit     send_idle_on = 1;
    bit     recv_idle_on = 1;
    bit     recv_hold = 0;
    int     quiet_cycles = 0;
    int     items_sent = 0;
    int     unsigned pts;

    localparam int QuietLimit = 20000;

    table_hunt_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_cmd(i_cmd),
        .i_point_index(i_point_index), .i_x_value(i_x_value), .i_y_value(i_y_value),
        .empty(empty), .pop(pop), .o_y_result(o_y_result), .o_status(o_status),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                board.note_input(t_cmd'(i_cmd), i_point_index, i_x_value, i_y_value);
            end
            if (pop && !empty) begin
                board.check_result(o_y_result, o_status);
            end
            if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog on cycles with no transfer at all.
    always @(posedge i_clk) begin
        if (quiet_cycles >= QuietLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n || recv_hold) pop <= 0;
        else pop <= recv_idle_on ? ($urandom_range(99) >= 16) : 1'b1;
    end

    // Offer one item and wait for its transfer; the next item may follow at once.
    task automatic send_item(t_cmd cmd, logic [7:0] idx, logic signed [31:0] x,
                             logic signed [31:0] y);
        while (send_idle_on && $urandom_range(99) < 16) @(negedge i_clk);
        push = 1'b1;
        i_cmd = cmd;
        i_point_index = idx;
        i_x_value = x;
        i_y_value = y;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        push = 1'b0;
        items_sent++;
    endtask

    task automatic wait_drained();
        while (board.want_y.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_count(int unsigned n);
        wait_drained();
        i_cfg_we <= 1;
        i_cfg_data <= n[8:0];
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.set_count(n[8:0]);
        pts = n < 2 ? 2 : (n > 256 ? 256 : n);
    endtask

    // Load a monotonic table of pts points with random steps (some zero width).
    task automatic load_table(bit asc, int unsigned span);
        longint signed x;
        logic signed [31:0] y;
        int unsigned step;
        x = asc ? -longint'($urandom_range(span)) - 64'sh40000000
                : longint'($urandom_range(span)) + 64'sh40000000;
        for (int unsigned i = 0; i < pts; i++) begin
            y = $urandom();
            send_item(CMD_WRITE, i[7:0], x[31:0], y);
            step = ($urandom_range(9) == 0) ? 0 : $urandom_range(span / pts + 1);
            x = asc ? x + step : x - step;
        end
    endtask

    task automatic random_lookups(int count);
        logic signed [31:0] x;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) == 0) x = $urandom();
            else x = board.x_tab[$urandom_range(pts - 1)] + $signed($urandom_range(4000)) - 2000;
            send_item(CMD_LOOKUP, 8'($urandom()), x, $urandom());
        end
    endtask

    initial begin
        board = new();
        board.clear();
        pts = 2;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: extreme values on a two-point table, both orders.
        send_item(CMD_WRITE, 8'd0, 32'sh80000000, 32'sh7FFFFFFF);
        send_item(CMD_WRITE, 8'd1, 32'sh7FFFFFFF, 32'sh80000000);
        send_item(CMD_LOOKUP, 8'hFF, 32'sh80000000, 32'sh7FFFFFFF);
        send_item(CMD_LOOKUP, 8'h00, 32'sh7FFFFFFF, 32'sh80000000);
        send_item(CMD_LOOKUP, 8'h00, 32'sh0, 32'sh0);
        send_item(CMD_LOOKUP, 8'h00, 32'sh1, 32'sh0);
        send_item(CMD_LOOKUP, 8'h00, -32'sh1, 32'sh0);
        send_item(CMD_WRITE, 8'd0, 32'sh00010000, 32'sh0);
        send_item(CMD_WRITE, 8'd1, -32'sh00010000, 32'sh00000003);
        send_item(CMD_LOOKUP, 8'h00, 32'sh00008000, 32'sh0);
        send_item(CMD_LOOKUP, 8'h00, -32'sh00008000, 32'sh0);
        send_item(CMD_LOOKUP, 8'h00, 32'sh00020000, 32'sh0);
        send_item(CMD_LOOKUP, 8'h00, -32'sh00020000, 32'sh0);
        // Ties in rounding, in both signs.
        send_item(CMD_WRITE, 8'd1, 32'sh00030000, 32'sh1);
        send_item(CMD_LOOKUP, 8'h00, 32'sh00020000, 32'sh0);
        send_item(CMD_WRITE, 8'd1, 32'sh00030000, -32'sh1);
        send_item(CMD_LOOKUP, 8'h00, 32'sh00020000, 32'sh0);
        // All-equal end points: clamp low wins.
        send_item(CMD_WRITE, 8'd1, 32'sh00010000, 32'sh5);
        send_item(CMD_LOOKUP, 8'h00, 32'sh00010000, 32'sh0);

        // Out-of-range counts saturate; then the largest table.
        write_count(0);
        send_item(CMD_LOOKUP, 8'h00, 32'sh0, 32'sh0);
        write_count(511);
        load_table(1, 32'h10000000);
        random_lookups(40);
        write_count(256);
        random_lookups(40);

        // Random phases over small and mid sizes and both orders.
        for (int ph = 0; ph < 30; ph++) begin
            write_count(ph % 7 == 0 ? 2 : $urandom_range(3, 24));
            send_idle_on = (ph != 5);
            recv_idle_on = (ph != 5);
            load_table(1'($urandom_range(1)), $urandom_range(1, 32'h3FFFFFFF));
            if (ph == 8) begin
                // Long receiver hold-off while the sender keeps offering.
                fork
                    begin
                        recv_hold = 1;
                        repeat (600) @(negedge i_clk);
                        recv_hold = 0;
                    end
                    random_lookups(20);
                join
            end
            random_lookups(19);
            // Hint survives only until a write; mix in a stray write at index 255.
            send_item(CMD_WRITE, 8'd255, $urandom(), $urandom());
            random_lookups(5);
        end

        wait_drained();
        $display("Sent %0d items; %0d results (%0d interpolated, %0d clamped or flat).",
                 items_sent, board.results_seen, board.interp_seen, board.clamp_seen);
        if (board.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
